[rtl/uns_pkg.sv]
// shared types and constants of the unigram negative sampler
package uns_pkg;

   // default sizes
   localparam int unsigned DefTableSize = 4096;
   localparam int unsigned DefMaxWords  = 1024;

   // fixed field widths
   localparam int unsigned FreqW    = 32;
   localparam int unsigned RandW    = 64;
   localparam int unsigned RandSkip = 16;
   localparam int unsigned WordW    = 10;
   localparam int unsigned ReqDataW = 96;
   localparam int unsigned RspDataW = 16;
   localparam int unsigned WeightW  = 32;

   // square root unit: 48-bit radicand, 24 root bits, two radicand bits a step
   localparam int unsigned SqValW  = 48;
   localparam int unsigned SqRootW = 24;
   localparam int unsigned SqRemW  = 27;
   localparam int unsigned SqSteps = 24;
   localparam int unsigned SqCntW  = 5;
   localparam int unsigned S2W     = 16;
   localparam int unsigned ProdW   = 40;

   // remainder of the shifted random word: reciprocal multiply in two halves,
   // then one correcting subtract
   localparam int unsigned ModValW  = 48;
   localparam int unsigned ModHalfW = 24;
   localparam int unsigned RecipW   = 45;
   localparam int unsigned ModAccW  = 93;
   localparam int unsigned ModSteps = 3;
   localparam int unsigned ModCntW  = 2;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_DRAW  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_BUILT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RES_ZERO = 2'd0,
      RES_LOAD = 2'd1,
      RES_DRAW = 2'd2
   } res_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SQ1,
      S_SQ2_LD,
      S_SQ2,
      S_MULW,
      S_STORE,
      S_B_RD,
      S_B_MUL,
      S_B_INIT,
      S_B_SLOT,
      S_D_MOD,
      S_D_RD,
      S_FIN
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        sq_start1;
      logic        sq_start2;
      logic        sq_step;
      logic        mul_w;
      logic        store_w;
      logic        b_start;
      logic        b_rd;
      logic        b_mul;
      logic        b_init;
      logic        b_slot;
      logic        b_finish;
      logic        b_empty;
      logic        mod_start;
      logic        mod_step;
      logic        d_rd;
      logic        res_set;
      res_sel_type res_sel;
      status_type  res_status;
      logic        res_push;
   } cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       full;
      logic       empty;
      logic       table_valid;
      logic       sq_last;
      logic       mod_last;
      logic       mod_needed;
      logic       b_init;
      logic       slot_adv;
      logic       slot_last;
      logic       out_free;
   } stat_type;

endpackage

[rtl/unigram_negative_sampler.sv]
// top level of the unigram negative sampler
// One item at a time. A load computes freq^0.75 with two 24-step sqrt passes
// and a multiply. A build walks all TABLE_SIZE slots, one slot a cycle, but
// stops to read and scale the next weight each time the word advances. A draw
// reduces the random word with a reciprocal multiply when TABLE_SIZE is not a
// power of two. A finished result waits in an output register; the next item
// is taken once it has been handed to that register.
module unigram_negative_sampler #(
   parameter int unsigned TABLE_SIZE = uns_pkg::DefTableSize,
   parameter int unsigned MAX_WORDS  = uns_pkg::DefMaxWords
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // frequency [31:0], random_value [95:32]
   input  logic [uns_pkg::ReqDataW-1:0] req_tdata,
   // opcode [1:0]
   input  logic [1:0]                   req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // word_index [9:0], zeros above
   output logic [uns_pkg::RspDataW-1:0] rsp_tdata,
   // status [1:0]
   output logic [1:0]                   rsp_tuser
);
   import uns_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // controller
   uns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath
   uns_dpath #(
      .TABLE_SIZE (TABLE_SIZE),
      .MAX_WORDS  (MAX_WORDS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

`ifndef SYNTHESIS
   // req_tready drops once an item has been accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while previous item in work");

   // error results carry no word
   a_error_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STAT_FULL || rsp_tuser == STAT_EMPTY ||
                      rsp_tuser == STAT_NOT_BUILT)) |-> (rsp_tdata == '0))
      else $error("error result with nonzero word index");

   // zero padding above the word index stays clear
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RspDataW-1:WordW] == '0))
      else $error("result padding bits set");
`endif

endmodule

[rtl/uns_ctrl.sv]
// controller state machine of the unigram negative sampler
module uns_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  uns_pkg::stat_type stat,
   output uns_pkg::cmd_type  cmd
);
   import uns_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (stat.opcode)
               OP_LOAD:  state_in = stat.full ? S_FIN : S_SQ1;
               OP_BUILD: state_in = stat.empty ? S_FIN : S_B_RD;
               OP_DRAW: begin
                  if (!stat.table_valid) state_in = S_FIN;
                  else if (stat.mod_needed) state_in = S_D_MOD;
                  else state_in = S_D_RD;
               end
               default: state_in = S_FIN;
            endcase
         end
         S_SQ1: begin
            if (stat.sq_last) state_in = S_SQ2_LD;
         end
         S_SQ2_LD: state_in = S_SQ2;
         S_SQ2: begin
            if (stat.sq_last) state_in = S_MULW;
         end
         S_MULW:   state_in = S_STORE;
         S_STORE:  state_in = S_FIN;
         S_B_RD:   state_in = S_B_MUL;
         S_B_MUL:  state_in = stat.b_init ? S_B_INIT : S_B_SLOT;
         S_B_INIT: state_in = S_B_RD;
         S_B_SLOT: begin
            if (stat.slot_last) state_in = S_FIN;
            else if (stat.slot_adv) state_in = S_B_RD;
         end
         S_D_MOD: begin
            if (stat.mod_last) state_in = S_D_RD;
         end
         S_D_RD: state_in = S_FIN;
         S_FIN: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      cmd.res_sel = RES_ZERO;
      cmd.res_status = STAT_OK;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.capture = req_tvalid;
         end
         S_DECODE: begin
            cmd.res_set = 1'b1;
            case (stat.opcode)
               OP_LOAD: begin
                  if (stat.full) cmd.res_status = STAT_FULL;
                  else cmd.sq_start1 = 1'b1;
               end
               OP_BUILD: begin
                  if (stat.empty) begin
                     cmd.res_status = STAT_EMPTY;
                     cmd.b_empty = 1'b1;
                  end else begin
                     cmd.b_start = 1'b1;
                  end
               end
               OP_DRAW: begin
                  if (!stat.table_valid) begin
                     cmd.res_status = STAT_NOT_BUILT;
                  end else begin
                     cmd.res_sel = RES_DRAW;
                     cmd.mod_start = stat.mod_needed;
                  end
               end
               default: cmd.res_status = STAT_OK;
            endcase
         end
         S_SQ1:    cmd.sq_step = 1'b1;
         S_SQ2_LD: cmd.sq_start2 = 1'b1;
         S_SQ2:    cmd.sq_step = 1'b1;
         S_MULW:   cmd.mul_w = 1'b1;
         S_STORE: begin
            cmd.store_w = 1'b1;
            cmd.res_set = 1'b1;
            cmd.res_sel = RES_LOAD;
         end
         S_B_RD:   cmd.b_rd = 1'b1;
         S_B_MUL:  cmd.b_mul = 1'b1;
         S_B_INIT: cmd.b_init = 1'b1;
         S_B_SLOT: begin
            cmd.b_slot = 1'b1;
            cmd.b_finish = stat.slot_last;
         end
         S_D_MOD: cmd.mod_step = 1'b1;
         S_D_RD:  cmd.d_rd = 1'b1;
         S_FIN:   cmd.res_push = stat.out_free;
         default: cmd.res_push = 1'b0;
      endcase
   end

endmodule

[rtl/uns_dpath.sv]
// datapath of the unigram negative sampler: weights, table, sqrt and remainder units
module uns_dpath #(
   parameter int unsigned TABLE_SIZE = uns_pkg::DefTableSize,
   parameter int unsigned MAX_WORDS  = uns_pkg::DefMaxWords
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [uns_pkg::ReqDataW-1:0]   req_tdata,
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [uns_pkg::RspDataW-1:0]   rsp_tdata,
   output logic [1:0]                     rsp_tuser,
   input  uns_pkg::cmd_type               cmd,
   output uns_pkg::stat_type              stat
);
   import uns_pkg::*;

   localparam int unsigned IW   = $clog2(MAX_WORDS);
   localparam int unsigned CW   = $clog2(MAX_WORDS + 1);
   localparam int unsigned TIW  = $clog2(TABLE_SIZE);
   localparam int unsigned SUMW = WeightW + IW;
   localparam int unsigned ACCW = SUMW + TIW;
   localparam int unsigned WTW  = WeightW + TIW;
   localparam bit          POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
   localparam logic [WTW-1:0]   TSZ_W = WTW'(TABLE_SIZE);
   localparam logic [TIW:0]     TSZ_M = (TIW + 1)'(TABLE_SIZE);
   localparam logic [TIW-1:0]   LAST_SLOT = TIW'(TABLE_SIZE - 1);
   localparam logic [CW-1:0]    FULL_CNT = CW'(MAX_WORDS);
   localparam logic [RecipW-1:0] RECIP =
      RecipW'((64'd1 << ModValW) / 64'(TABLE_SIZE));

   // captured item
   opcode_type         opcode_ff;
   logic [FreqW-1:0]   freq_ff;
   logic [RandW-1:0]   rnd_ff;

   // vocabulary state
   logic [CW-1:0]      count_ff;
   logic [SUMW-1:0]    sum_ff;
   logic               valid_ff;

   // square root unit
   logic [SqValW-1:0]  sq_val_ff;
   logic [SqRootW-1:0] sq_root_ff;
   logic [SqRemW-1:0]  sq_rem_ff;
   logic [SqCntW-1:0]  sq_cnt_ff;
   logic [SqRootW-1:0] s1_ff;
   logic [ProdW-1:0]   prod_ff;
   logic [SqRemW-1:0]  sq_rem_in;
   logic [SqRemW-1:0]  sq_trial;
   logic [WeightW-1:0] weight;

   // build state
   logic [IW-1:0]      cur_ff;
   logic [TIW-1:0]     slot_ff;
   logic [ACCW-1:0]    accl_ff;
   logic [ACCW-1:0]    accr_ff;
   logic [WTW-1:0]     wt_ff;
   logic               init_ff;
   logic [WeightW-1:0] w_rdata_ff;
   logic [IW-1:0]      w_raddr;

   // remainder unit
   logic [ModValW-1:0]         mod_val_ff;
   logic [ModAccW-1:0]         mod_acc_ff;
   logic [TIW-1:0]             mod_r_ff;
   logic [ModCntW-1:0]         mod_cnt_ff;
   logic [ModHalfW-1:0]        mod_half;
   logic [ModHalfW+RecipW-1:0] mod_part;
   logic [TIW:0]               mod_q;
   logic [2*TIW+1:0]           mod_qt;
   logic [TIW:0]               mod_r0;
   logic [TIW-1:0]             draw_idx;

   // memories
   logic [WeightW-1:0] weight_mem [MAX_WORDS];
   logic [IW-1:0]      table_mem [TABLE_SIZE];
   logic [IW-1:0]      t_rdata_ff;

   // pending and output result
   res_sel_type        res_sel_ff;
   status_type         res_stat_ff;
   logic [IW-1:0]      res_word_ff;
   logic               rsp_valid_ff;
   logic [WordW-1:0]   rsp_word_ff;
   status_type         rsp_stat_ff;
   logic               out_free;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff <= opcode_type'(req_tuser);
         freq_ff   <= req_tdata[FreqW-1:0];
         rnd_ff    <= req_tdata[FreqW +: RandW];
      end
   end

   // one sqrt step: bring down two radicand bits, try root*4+1
   always_comb begin
      sq_rem_in = {sq_rem_ff[SqRemW-3:0], sq_val_ff[SqValW-1 -: 2]};
      sq_trial  = {1'b0, sq_root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_start1 || cmd.sq_start2) begin
         sq_val_ff  <= cmd.sq_start1 ? {freq_ff, 16'd0} : {16'd0, sq_root_ff, 8'd0};
         sq_root_ff <= '0;
         sq_rem_ff  <= '0;
         sq_cnt_ff  <= SqCntW'(SqSteps);
      end else if (cmd.sq_step) begin
         sq_val_ff <= {sq_val_ff[SqValW-3:0], 2'b00};
         sq_cnt_ff <= sq_cnt_ff - 1'b1;
         if (sq_rem_in >= sq_trial) begin
            sq_rem_ff  <= sq_rem_in - sq_trial;
            sq_root_ff <= {sq_root_ff[SqRootW-2:0], 1'b1};
         end else begin
            sq_rem_ff  <= sq_rem_in;
            sq_root_ff <= {sq_root_ff[SqRootW-2:0], 1'b0};
         end
      end
      if (cmd.sq_start2) s1_ff <= sq_root_ff;
      if (cmd.mul_w) prod_ff <= s1_ff * sq_root_ff[S2W-1:0];
   end

   assign weight = prod_ff[ProdW-1:8];

   // vocabulary count, weight sum and table flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.store_w) begin
            count_ff <= count_ff + 1'b1;
            sum_ff   <= sum_ff + SUMW'(weight);
            valid_ff <= 1'b0;
         end else if (cmd.b_empty) begin
            valid_ff <= 1'b0;
         end else if (cmd.b_finish) begin
            valid_ff <= 1'b1;
         end
      end
   end

   // weight memory
   assign w_raddr = init_ff ? '0 : cur_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.store_w) weight_mem[count_ff[IW-1:0]] <= weight;
      if (cmd.b_rd) w_rdata_ff <= weight_mem[w_raddr];
   end

   // table build walk: left side i*sum, right side cum*TABLE_SIZE
   always_ff @(posedge clock) begin
      if (cmd.b_start) begin
         cur_ff  <= '0;
         slot_ff <= '0;
         accl_ff <= '0;
         init_ff <= 1'b1;
      end
      if (cmd.b_mul) wt_ff <= WTW'(w_rdata_ff) * TSZ_W;
      if (cmd.b_init) begin
         accr_ff <= ACCW'(wt_ff);
         init_ff <= 1'b0;
      end
      if (cmd.b_slot) begin
         slot_ff <= slot_ff + 1'b1;
         accl_ff <= accl_ff + ACCW'(sum_ff);
         if (stat.slot_adv) begin
            cur_ff  <= cur_ff + 1'b1;
            accr_ff <= accr_ff + ACCW'(wt_ff);
         end
      end
   end

   // remainder of the random word by the table size: quotient estimate from
   // the reciprocal, low half then high half, at most one table size too low
   assign mod_half = (mod_cnt_ff == ModCntW'(ModSteps)) ? mod_val_ff[ModHalfW-1:0]
                                                        : mod_val_ff[ModValW-1 -: ModHalfW];
   assign mod_part = mod_half * RECIP;
   assign mod_q    = mod_acc_ff[ModValW +: (TIW + 1)];
   assign mod_qt   = mod_q * TSZ_M;
   assign mod_r0   = mod_val_ff[TIW:0] - mod_qt[TIW:0];

   always_ff @(posedge clock) begin
      if (cmd.mod_start) begin
         mod_val_ff <= rnd_ff[RandSkip +: ModValW];
         mod_cnt_ff <= ModCntW'(ModSteps);
      end else if (cmd.mod_step) begin
         mod_cnt_ff <= mod_cnt_ff - 1'b1;
         if (mod_cnt_ff == ModCntW'(ModSteps)) begin
            mod_acc_ff <= ModAccW'(mod_part);
         end else if (mod_cnt_ff == ModCntW'(ModSteps - 1)) begin
            mod_acc_ff <= mod_acc_ff + {mod_part, {ModHalfW{1'b0}}};
         end else if (mod_r0 >= TSZ_M) begin
            mod_r_ff <= TIW'(mod_r0 - TSZ_M);
         end else begin
            mod_r_ff <= TIW'(mod_r0);
         end
      end
   end

   assign draw_idx = POW2 ? rnd_ff[RandSkip +: TIW] : mod_r_ff;

   // sample table
   always_ff @(posedge clock) begin
      if (cmd.b_slot) table_mem[slot_ff] <= cur_ff;
      if (cmd.d_rd) t_rdata_ff <= table_mem[draw_idx];
   end

   // pending result
   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_sel_ff  <= cmd.res_sel;
         res_stat_ff <= cmd.res_status;
         res_word_ff <= count_ff[IW-1:0];
      end
   end

   // output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_push) begin
         rsp_stat_ff <= res_stat_ff;
         case (res_sel_ff)
            RES_LOAD: rsp_word_ff <= WordW'(res_word_ff);
            RES_DRAW: rsp_word_ff <= WordW'(t_rdata_ff);
            default:  rsp_word_ff <= '0;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspDataW'(rsp_word_ff);
   assign rsp_tuser  = rsp_stat_ff;

   // status to the controller
   always_comb begin
      stat.opcode      = opcode_ff;
      stat.full        = count_ff == FULL_CNT;
      stat.empty       = count_ff == '0;
      stat.table_valid = valid_ff;
      stat.sq_last     = sq_cnt_ff == SqCntW'(1);
      stat.mod_last    = mod_cnt_ff == ModCntW'(1);
      stat.mod_needed  = !POW2;
      stat.b_init      = init_ff;
      stat.slot_adv    = (accl_ff > accr_ff) && ((CW'(cur_ff) + 1'b1) < count_ff);
      stat.slot_last   = slot_ff == LAST_SLOT;
      stat.out_free    = out_free;
   end

endmodule
